// ===== src/psc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, codes and types of the part sorting classifier.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int KIND_W    = 2;
   localparam int SAMPLE_W  = 10;
   localparam int SPP_W     = 7;
   localparam int STATUS_W  = 3;
   localparam int CLASS_W   = 3;
   localparam int DIR_W     = 2;
   localparam int STEPS_W   = 8;
   localparam int PENDING_W = 5;
   localparam int TOTAL_W   = 8;
   localparam int NUM_CLASS = 4;
   localparam int CSR_IDX_W = 3;

   // request kinds
   localparam logic [KIND_W-1:0] REQ_START    = 2'd0;
   localparam logic [KIND_W-1:0] REQ_SAMPLE   = 2'd1;
   localparam logic [KIND_W-1:0] REQ_DISPATCH = 2'd2;

   // result status
   localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CLASSIFIED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;

   // class codes
   localparam logic [CLASS_W-1:0] CLS_NONE      = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_BLACK     = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_STEEL     = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_WHITE     = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_ALUMINIUM = 3'd4;

   // tray move direction
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_CCW  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_CW   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALUMINIUM_MAX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEEL_LOW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEEL_HIGH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_LOW     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_POS = 3'd4;

   // reset values
   localparam logic [SAMPLE_W-1:0] INIT_MINIMUM      = 10'h3FF;
   localparam logic [SAMPLE_W-1:0] RST_ALUMINIUM_MAX = 10'd350;
   localparam logic [SAMPLE_W-1:0] RST_STEEL_LOW     = 10'd400;
   localparam logic [SAMPLE_W-1:0] RST_STEEL_HIGH    = 10'd800;
   localparam logic [SAMPLE_W-1:0] RST_BLACK_LOW     = 10'd940;
   localparam logic [SPP_W-1:0]    RST_STEPS_PER_POS = 7'd50;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic [KIND_W-1:0]   req_type;
      logic [SAMPLE_W-1:0] sample;
      logic                part_present;
   } item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] aluminium_max;
      logic [SAMPLE_W-1:0] steel_low;
      logic [SAMPLE_W-1:0] steel_high;
      logic [SAMPLE_W-1:0] black_low;
      logic [SPP_W-1:0]    steps_per_position;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [CLASS_W-1:0]   class_code;
      logic [DIR_W-1:0]     direction;
      logic [STEPS_W-1:0]   step_count;
      logic [PENDING_W-1:0] pending;
      logic [TOTAL_W-1:0]   black_total;
      logic [TOTAL_W-1:0]   steel_total;
      logic [TOTAL_W-1:0]   white_total;
      logic [TOTAL_W-1:0]   aluminium_total;
   } result_type;

endpackage

// ===== src/psc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_req_if
// Event channel into the classifier: valid/ready with the event fields.
// ----------------------------------------------------------------------------
interface psc_req_if;
   logic                          valid;
   logic                          ready;
   logic [psc_pkg::KIND_W-1:0]    req_type;
   logic [psc_pkg::SAMPLE_W-1:0]  sample;
   logic                          part_present;

   modport source (output valid, output req_type, output sample, output part_present,
                   input ready);
   modport sink   (input valid, input req_type, input sample, input part_present,
                   output ready);
endinterface

// ===== src/psc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_rsp_if
// Result channel out of the classifier: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface psc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [psc_pkg::STATUS_W-1:0]   status;
   logic [psc_pkg::CLASS_W-1:0]    class_code;
   logic [psc_pkg::DIR_W-1:0]      direction;
   logic [psc_pkg::STEPS_W-1:0]    step_count;
   logic [psc_pkg::PENDING_W-1:0]  pending;
   logic [psc_pkg::TOTAL_W-1:0]    black_total;
   logic [psc_pkg::TOTAL_W-1:0]    steel_total;
   logic [psc_pkg::TOTAL_W-1:0]    white_total;
   logic [psc_pkg::TOTAL_W-1:0]    aluminium_total;

   modport source (output valid, output status, output class_code, output direction,
                   output step_count, output pending, output black_total,
                   output steel_total, output white_total, output aluminium_total,
                   input ready);
   modport sink   (input valid, input status, input class_code, input direction,
                   input step_count, input pending, input black_total,
                   input steel_total, input white_total, input aluminium_total,
                   output ready);
endinterface

// ===== src/part_sort_classifier_dispatch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// part_sort_classifier_dispatch
// Reflectance classifier for a part sorter, with class queue and tray dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries events: start (clear the running minimum), sample (fold a
//   reading in; classify once part_present is low) and dispatch (pop the oldest
//   class and report the shortest tray move). Every event gives one transfer
//   on rsp_chan with status, class, move and the four wrapping class totals.
//   csr_we/csr_index/csr_wdata write the thresholds and steps per position;
//   write them only while no event is in flight.
// Timing:
//   An accepted event is held in the input register, is processed in a
//   single combinational pass and is written to the result register once
//   that register is empty or its result is being taken; it stays valid
//   until taken. One event per cycle is sustained while rsp_chan.ready is
//   high; the rate is set by that single pass (compare, counter, queue).
// Reset (synchronous): queue empty, minimum 1023, tray at black, totals zero,
//   registers at their defaults.
// Stall: a result held on rsp_chan keeps its value; one more event is still
//   taken into the input register, after which req_chan.ready drops.
// ----------------------------------------------------------------------------
module part_sort_classifier_dispatch #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   psc_req_if.sink                         req_chan,
   psc_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [psc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psc_pkg::SAMPLE_W-1:0]    csr_wdata
);

   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   // classification order: aluminium, steel window, black, else white
   function automatic logic [psc_pkg::CLASS_W-1:0] classify(
      input logic [psc_pkg::SAMPLE_W-1:0] m,
      input psc_pkg::cfg_type              c
   );
      logic [psc_pkg::CLASS_W-1:0] r;
      if (m < c.aluminium_max) begin
         r = psc_pkg::CLS_ALUMINIUM;
      end else if ((m > c.steel_low) && (m < c.steel_high)) begin
         r = psc_pkg::CLS_STEEL;
      end else if (m > c.black_low) begin
         r = psc_pkg::CLS_BLACK;
      end else begin
         r = psc_pkg::CLS_WHITE;
      end
      return r;
   endfunction

   psc_pkg::cfg_type     cfg_ff;
   psc_pkg::item_type    item_ff;
   logic                 item_vld_ff, item_vld_in;
   psc_pkg::result_type  rsp_ff, rsp_in;
   logic                 rsp_vld_ff, rsp_vld_in;

   logic [psc_pkg::SAMPLE_W-1:0] min_ff, min_in, new_min;
   logic [psc_pkg::CLASS_W-1:0]  tray_ff, tray_in;
   logic [psc_pkg::TOTAL_W-1:0]  totals_ff [psc_pkg::NUM_CLASS];
   logic [psc_pkg::TOTAL_W-1:0]  totals_in [psc_pkg::NUM_CLASS];

   logic                         take, advance;
   psc_pkg::fifo_ctl_type        fifo_req, fifo_ctl;
   logic [psc_pkg::CLASS_W-1:0]  cls, head;
   logic [1:0]                   cls_idx;
   logic [FW-1:0]                fill, fill_after;
   logic signed [3:0]            move;
   logic [1:0]                   mag;

   // ---- handshake: input register, then result register ----
   assign advance        = item_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !item_vld_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign item_vld_in    = take || (item_vld_ff && !advance);
   assign rsp_vld_in     = advance || (rsp_vld_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.req_type     <= req_chan.req_type;
         item_ff.sample       <= req_chan.sample;
         item_ff.part_present <= req_chan.part_present;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.aluminium_max      <= psc_pkg::RST_ALUMINIUM_MAX;
         cfg_ff.steel_low          <= psc_pkg::RST_STEEL_LOW;
         cfg_ff.steel_high         <= psc_pkg::RST_STEEL_HIGH;
         cfg_ff.black_low          <= psc_pkg::RST_BLACK_LOW;
         cfg_ff.steps_per_position <= psc_pkg::RST_STEPS_PER_POS;
      end else if (csr_we) begin
         case (csr_index)
            psc_pkg::CSR_ALUMINIUM_MAX: cfg_ff.aluminium_max <= csr_wdata;
            psc_pkg::CSR_STEEL_LOW:     cfg_ff.steel_low     <= csr_wdata;
            psc_pkg::CSR_STEEL_HIGH:    cfg_ff.steel_high    <= csr_wdata;
            psc_pkg::CSR_BLACK_LOW:     cfg_ff.black_low     <= csr_wdata;
            psc_pkg::CSR_STEPS_PER_POS: begin
               cfg_ff.steps_per_position <= csr_wdata[psc_pkg::SPP_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // ---- class queue ----
   assign fifo_ctl.push = advance && fifo_req.push;
   assign fifo_ctl.pop  = advance && fifo_req.pop;

   psc_class_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fifo_ctl),
      .push_data (cls),
      .head      (head),
      .fill      (fill)
   );

   // ---- single processing pass ----
   assign new_min = (item_ff.sample < min_ff) ? item_ff.sample : min_ff;
   assign cls     = classify(new_min, cfg_ff);
   assign cls_idx = 2'(cls - psc_pkg::CLS_BLACK);

   always_comb begin
      min_in     = min_ff;
      tray_in    = tray_ff;
      totals_in  = totals_ff;
      fifo_req   = '0;
      move       = '0;
      mag        = '0;
      rsp_in     = '0;
      fill_after = fill;

      case (item_ff.req_type)
         psc_pkg::REQ_START: begin
            min_in = psc_pkg::INIT_MINIMUM;
         end
         psc_pkg::REQ_SAMPLE: begin
            min_in = new_min;
            if (!item_ff.part_present) begin
               rsp_in.class_code  = cls;
               totals_in[cls_idx] = totals_ff[cls_idx] + psc_pkg::TOTAL_W'(1);
               if (fill == FW'(QUEUE_DEPTH)) begin
                  rsp_in.status = psc_pkg::ST_DROPPED;
               end else begin
                  fifo_req.push = 1'b1;
                  rsp_in.status = psc_pkg::ST_CLASSIFIED;
               end
            end
         end
         psc_pkg::REQ_DISPATCH: begin
            if (fill == '0) begin
               rsp_in.status = psc_pkg::ST_EMPTY;
            end else begin
               fifo_req.pop      = 1'b1;
               rsp_in.class_code = head;
               rsp_in.status     = psc_pkg::ST_DISPATCHED;
               tray_in           = head;
               move = $signed({1'b0, head}) - $signed({1'b0, tray_ff});
               // a three-position move is one position the other way
               if (move == 4'sd3) begin
                  move = -4'sd1;
               end else if (move == -4'sd3) begin
                  move = 4'sd1;
               end
               if (move > 4'sd0) begin
                  rsp_in.direction = psc_pkg::DIR_CCW;
                  mag              = move[1:0];
               end else if (move < 4'sd0) begin
                  rsp_in.direction = psc_pkg::DIR_CW;
                  mag              = 2'(-move);
               end
               case (mag)
                  2'd1:    rsp_in.step_count = {1'b0, cfg_ff.steps_per_position};
                  2'd2:    rsp_in.step_count = {cfg_ff.steps_per_position, 1'b0};
                  default: rsp_in.step_count = '0;
               endcase
            end
         end
         default: ;
      endcase

      // queue occupancy after this event
      if (fifo_req.push) begin
         fill_after = fill + FW'(1);
      end else if (fifo_req.pop) begin
         fill_after = fill - FW'(1);
      end

      rsp_in.pending         = psc_pkg::PENDING_W'(fill_after);
      rsp_in.black_total     = totals_in[0];
      rsp_in.steel_total     = totals_in[1];
      rsp_in.white_total     = totals_in[2];
      rsp_in.aluminium_total = totals_in[3];
   end

   // ---- running state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= psc_pkg::INIT_MINIMUM;
         tray_ff <= psc_pkg::CLS_BLACK;
         for (int i = 0; i < psc_pkg::NUM_CLASS; i++) begin
            totals_ff[i] <= '0;
         end
      end else if (advance) begin
         min_ff    <= min_in;
         tray_ff   <= tray_in;
         totals_ff <= totals_in;
      end
   end

   // ---- result channel ----
   assign rsp_chan.valid           = rsp_vld_ff;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.class_code      = rsp_ff.class_code;
   assign rsp_chan.direction       = rsp_ff.direction;
   assign rsp_chan.step_count      = rsp_ff.step_count;
   assign rsp_chan.pending         = rsp_ff.pending;
   assign rsp_chan.black_total     = rsp_ff.black_total;
   assign rsp_chan.steel_total     = rsp_ff.steel_total;
   assign rsp_chan.white_total     = rsp_ff.white_total;
   assign rsp_chan.aluminium_total = rsp_ff.aluminium_total;

endmodule

// ===== src/psc_class_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_class_fifo
// Class queue: circular buffer with registered head read and write bypass.
// ----------------------------------------------------------------------------
module psc_class_fifo #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  psc_pkg::fifo_ctl_type                  ctl,
   input  logic [psc_pkg::CLASS_W-1:0]            push_data,
   output logic [psc_pkg::CLASS_W-1:0]            head,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       fill
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

   logic [psc_pkg::CLASS_W-1:0] queue_ff [QUEUE_DEPTH];
   logic [psc_pkg::CLASS_W-1:0] head_ff;
   logic [AW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [FW-1:0]               fill_ff, fill_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (ctl.push && !ctl.pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (ctl.pop && !ctl.push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   // head tracks the entry at the next read pointer; a write to that slot bypasses
   always_ff @(posedge clock) begin
      if (ctl.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_data;
      end else begin
         head_ff <= queue_ff[rd_ptr_in];
      end
   end

   assign head = head_ff;
   assign fill = fill_ff;

endmodule
